>>> rtl/pns_pkg.sv
`default_nettype none

package pns_pkg;

    // fixed field widths
    localparam int DIM_W   = 9;
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = DIM_W + FRAC_W;
    localparam int RAW_W   = 17;
    localparam int MARG_W  = 7;
    localparam int PROD_W  = 18;
    localparam int SXN_W   = 17;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 16;
    localparam int CIDX_W  = 3;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
    localparam logic [CIDX_W-1:0] REG_PERSPECTIVE   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_BACKGROUND    = 3'd5;

    // ratio unit status
    typedef struct packed {
        logic               busy;
        logic [RATIO_W-1:0] x_ratio;
        logic [RATIO_W-1:0] y_ratio;
    } ratio_t;

    // input beat as captured
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] load_address;
        logic [PIX_W-1:0]  load_pixel;
        logic [7:0]        dest_x;
        logic [7:0]        dest_y;
    } in_beat_t;

    // side data carried through the margin divider
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic [7:0]        dx;
        logic [RAW_W-1:0]  sy_raw;
        logic [RAW_W-1:0]  sx_plain;
    } mpay_t;

    // side data carried through the column divider
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic [RAW_W-1:0]  sy_raw;
        logic [RAW_W-1:0]  sx_plain;
        logic              in_m;
    } cpay_t;

    // zero acts as one, oversize acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [10:0] mx);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if ({2'b00, v} > mx)
            r = mx[DIM_W-1:0];
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/perspective_nearest_scaler.sv
// perspective_nearest_scaler: nearest-neighbor resampler with optional
// trapezoid margin, source image held in an internal pixel store.
// input channel (in_valid / in_stall): op = 0 writes load_pixel at
// load_address, op = 1 samples destination pixel (dest_x, dest_y).
// output channel (out_valid / out_stall): one beat per sample that lies
// inside the target, pixel_out plus in_margin; loads give no beat.
// configuration: cfg_we writes cfg_data into register cfg_index; the user
// must write only while the block is idle, which the block does not enforce.
// pipeline: capture, stage 2, margin divider, stage 3, column divider,
// stage 4 and output stage; one beat per cycle is accepted while in_stall
// is low, the depth set by the two bit-serial divider pipes (7 margin
// stages, 9 column stages) plus the store read.
// after reset and after every configuration write the ratio unit recomputes
// the ratios and holds in_stall high meanwhile.
// when out_stall holds the output beat, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// the store depth must be a power of two, unchecked; read indexes wrap on it.
`default_nettype none

module perspective_nearest_scaler import pns_pkg::*; #(
    parameter int MAX_DIMENSION = 256,
    parameter int STORE_DEPTH   = 65536
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              op,
    input  wire logic [ADDR_W-1:0] load_address,
    input  wire logic [PIX_W-1:0]  load_pixel,
    input  wire logic [7:0]        dest_x,
    input  wire logic [7:0]        dest_y,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [PIX_W-1:0]  pixel_out,
    output logic                   in_margin
);

    localparam int AW = $clog2(STORE_DEPTH);

    // configuration registers
    logic [DIM_W-1:0] sw_reg, sh_reg, tw_reg, th_reg;
    logic             persp_reg;
    logic [PIX_W-1:0] bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= DIM_W'(160);
            sh_reg    <= DIM_W'(160);
            tw_reg    <= DIM_W'(160);
            th_reg    <= DIM_W'(160);
            persp_reg <= 1'b0;
            bg_reg    <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  sw_reg    <= cfg_data[DIM_W-1:0];
                REG_SOURCE_HEIGHT: sh_reg    <= cfg_data[DIM_W-1:0];
                REG_TARGET_WIDTH:  tw_reg    <= cfg_data[DIM_W-1:0];
                REG_TARGET_HEIGHT: th_reg    <= cfg_data[DIM_W-1:0];
                REG_PERSPECTIVE:   persp_reg <= cfg_data[0];
                REG_BACKGROUND:    bg_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // effective dimensions
    logic [DIM_W-1:0] sw, sh, tw, th;
    assign sw = clamp_dim(sw_reg, 11'(MAX_DIMENSION));
    assign sh = clamp_dim(sh_reg, 11'(MAX_DIMENSION));
    assign tw = clamp_dim(tw_reg, 11'(MAX_DIMENSION));
    assign th = clamp_dim(th_reg, 11'(MAX_DIMENSION));

    // axis ratios
    ratio_t ratio;

    pns_ratio u_ratio (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .sw      (sw),
        .sh      (sh),
        .tw      (tw),
        .th      (th),
        .status  (ratio)
    );

    // global advance: the output stage is free or being taken
    logic adv, in_acc, r_valid_reg;
    assign adv      = !(r_valid_reg && out_stall);
    assign in_stall = ratio.busy || !adv;
    assign in_acc   = in_valid && !in_stall;

    // stage 1: capture beat
    logic     s1_valid_reg;
    in_beat_t s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.op           <= op;
            s1_reg.load_address <= load_address;
            s1_reg.load_pixel   <= load_pixel;
            s1_reg.dest_x       <= dest_x;
            s1_reg.dest_y       <= dest_y;
        end
    end

    // stage 2: range filter, row distance product, plain ratio products
    logic              keep;
    logic [DIM_W-1:0]  centre, row_dist;
    logic [32:0]       sy_full, sx_full;
    logic              s2_valid_next;
    logic              s2_valid_reg;
    mpay_t             s2_pay_next, s2_pay_reg;
    logic [PROD_W-1:0] s2_prod_next, s2_prod_reg;

    always_comb
    begin
        if (s1_reg.op == OP_SAMPLE)
        begin
            keep = ({1'b0, s1_reg.dest_x} < tw) && ({1'b0, s1_reg.dest_y} < th);
        end
        else
        begin
            keep = 32'(s1_reg.load_address) < 32'(STORE_DEPTH);
        end
        s2_valid_next = s1_valid_reg && keep;
        centre = {1'b0, th[DIM_W-1:1]};
        if ({1'b0, s1_reg.dest_y} >= centre)
        begin
            row_dist = {1'b0, s1_reg.dest_y} - centre;
        end
        else
        begin
            row_dist = centre - {1'b0, s1_reg.dest_y};
        end
        s2_prod_next = PROD_W'(row_dist) * PROD_W'(tw);
        sy_full = 33'(s1_reg.dest_y) * 33'(ratio.y_ratio);
        sx_full = 33'(s1_reg.dest_x) * 33'(ratio.x_ratio);
        s2_pay_next.op       = s1_reg.op;
        s2_pay_next.addr     = s1_reg.load_address;
        s2_pay_next.pix      = s1_reg.load_pixel;
        s2_pay_next.dx       = s1_reg.dest_x;
        s2_pay_next.sy_raw   = sy_full[32:FRAC_W];
        s2_pay_next.sx_plain = sx_full[32:FRAC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pay_reg  <= s2_pay_next;
            s2_prod_reg <= s2_prod_next;
        end
    end

    // margin = row distance * tw / (3 * th)
    logic              md_valid;
    logic [MARG_W-1:0] margin;
    logic [$bits(mpay_t)-1:0] md_pay_bits;
    mpay_t             md_pay;
    logic [DIM_W+1:0]  th3;

    assign th3 = (DIM_W+2)'(th) * (DIM_W+2)'(3);

    pns_divpipe #(
        .NUM_W (PROD_W),
        .DEN_W (DIM_W + 2),
        .QUO_W (MARG_W),
        .PAY_W ($bits(mpay_t))
    ) u_margin_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_valid_reg),
        .num       (s2_prod_reg),
        .den       (th3),
        .pay_in    (s2_pay_reg),
        .out_valid (md_valid),
        .quo       (margin),
        .pay_out   (md_pay_bits)
    );

    assign md_pay = mpay_t'(md_pay_bits);

    // stage 3: margin test, narrowed line, column numerator
    logic [DIM_W:0]   tw_m, two_m;
    logic [7:0]       dx_off;
    logic             s3_valid_reg;
    cpay_t            s3_pay_next, s3_pay_reg;
    logic [SXN_W-1:0] s3_num_next, s3_num_reg;
    logic [DIM_W-1:0] s3_line_next, s3_line_reg;

    always_comb
    begin
        tw_m  = {1'b0, tw} - (DIM_W+1)'(margin);
        two_m = (DIM_W+1)'({margin, 1'b0});
        s3_pay_next.op       = md_pay.op;
        s3_pay_next.addr     = md_pay.addr;
        s3_pay_next.pix      = md_pay.pix;
        s3_pay_next.sy_raw   = md_pay.sy_raw;
        s3_pay_next.sx_plain = md_pay.sx_plain;
        s3_pay_next.in_m     = persp_reg &&
            ((md_pay.dx < 8'(margin)) || ({2'b00, md_pay.dx} > tw_m));
        if ({1'b0, tw} > two_m)
        begin
            s3_line_next = DIM_W'({1'b0, tw} - two_m);
        end
        else
        begin
            s3_line_next = DIM_W'(1);
        end
        dx_off      = md_pay.dx - 8'(margin);
        s3_num_next = SXN_W'(dx_off) * SXN_W'(sw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= md_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_pay_reg  <= s3_pay_next;
            s3_num_reg  <= s3_num_next;
            s3_line_reg <= s3_line_next;
        end
    end

    // perspective column = (dx - margin) * sw / line
    logic             cd_valid;
    logic [DIM_W-1:0] sx_persp;
    logic [$bits(cpay_t)-1:0] cd_pay_bits;
    cpay_t            cd_pay;

    pns_divpipe #(
        .NUM_W (SXN_W),
        .DEN_W (DIM_W),
        .QUO_W (DIM_W),
        .PAY_W ($bits(cpay_t))
    ) u_column_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .num       (s3_num_reg),
        .den       (s3_line_reg),
        .pay_in    (s3_pay_reg),
        .out_valid (cd_valid),
        .quo       (sx_persp),
        .pay_out   (cd_pay_bits)
    );

    assign cd_pay = cpay_t'(cd_pay_bits);

    // stage 4: clamp coordinates, form store address
    logic [RAW_W-1:0] sx_raw;
    logic [DIM_W-1:0] sx_c, sy_c;
    logic [18:0]      idx;
    logic             s4_valid_reg, s4_op_reg, s4_in_m_reg;
    logic [AW-1:0]    s4_addr_next, s4_addr_reg;
    logic [PIX_W-1:0] s4_pix_reg;

    always_comb
    begin
        sx_raw = persp_reg ? RAW_W'(sx_persp) : cd_pay.sx_plain;
        sx_c = (sx_raw >= RAW_W'(sw)) ? (sw - DIM_W'(1)) : sx_raw[DIM_W-1:0];
        sy_c = (cd_pay.sy_raw >= RAW_W'(sh)) ? (sh - DIM_W'(1))
                                             : cd_pay.sy_raw[DIM_W-1:0];
        idx  = 19'(18'(sy_c) * 18'(sw)) + 19'(sx_c);
        s4_addr_next = (cd_pay.op == OP_LOAD) ? AW'(cd_pay.addr) : AW'(idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_op_reg   <= cd_pay.op;
            s4_in_m_reg <= cd_pay.in_m;
            s4_addr_reg <= s4_addr_next;
            s4_pix_reg  <= cd_pay.pix;
        end
    end

    // pixel store: loads write and samples read at the same stage
    logic [PIX_W-1:0] ram_q;

    pns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (adv && s4_valid_reg && (s4_op_reg == OP_LOAD)),
        .waddr (s4_addr_reg),
        .wdata (s4_pix_reg),
        .re    (adv),
        .raddr (s4_addr_reg),
        .rdata (ram_q)
    );

    // stage 5: output beat
    logic r_in_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= s4_valid_reg && (s4_op_reg == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_in_m_reg <= s4_in_m_reg;
        end
    end

    assign out_valid = r_valid_reg;
    assign in_margin = r_in_m_reg;
    assign pixel_out = r_in_m_reg ? bg_reg : ram_q;

    // margin beats only come out in perspective mode
    a_margin_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_margin) |-> persp_reg)
        else $error("margin beat outside perspective mode");

    // a register write restarts the ratio unit, so nothing enters next cycle
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("beat accepted while ratios recompute");

    // ratios settle before any beat is taken
    a_ratio_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !ratio.busy)
        else $error("beat accepted with busy ratio unit");

endmodule

`default_nettype wire

>>> rtl/pns_ram.sv
`default_nettype none

module pns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pns_divpipe.sv
`default_nettype none

module pns_divpipe #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 9,
    parameter int QUO_W = 9,
    parameter int PAY_W = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [PAY_W-1:0] pay_in,
    output logic                  out_valid,
    output logic      [QUO_W-1:0] quo,
    output logic      [PAY_W-1:0] pay_out
);

    localparam int CW = NUM_W + DEN_W + QUO_W;

    logic             v_reg   [QUO_W];
    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] q_reg   [QUO_W];
    logic [PAY_W-1:0] pay_reg [QUO_W];

    // one quotient bit per stage, most significant first
    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            logic             v_in;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [QUO_W-1:0] q_in;
            logic [PAY_W-1:0] pay_in_k;
            logic [CW-1:0]    shifted;
            logic             ge;
            logic [NUM_W-1:0] rem_next;
            logic [QUO_W-1:0] q_next;

            if (k == 0)
            begin : g_first
                assign v_in     = in_valid;
                assign rem_in   = num;
                assign den_in   = den;
                assign q_in     = '0;
                assign pay_in_k = pay_in;
            end
            else
            begin : g_chain
                assign v_in     = v_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign den_in   = den_reg[k-1];
                assign q_in     = q_reg[k-1];
                assign pay_in_k = pay_reg[k-1];
            end

            // trial subtract of the shifted divisor
            always_comb
            begin
                shifted  = CW'(den_in) << (QUO_W - 1 - k);
                ge       = CW'(rem_in) >= shifted;
                rem_next = ge ? NUM_W'(CW'(rem_in) - shifted) : rem_in;
                q_next   = ge ? (q_in | (QUO_W'(1) << (QUO_W - 1 - k))) : q_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    q_reg[k]   <= q_next;
                    pay_reg[k] <= pay_in_k;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QUO_W-1];
    assign quo       = q_reg[QUO_W-1];
    assign pay_out   = pay_reg[QUO_W-1];

endmodule

`default_nettype wire

>>> rtl/pns_ratio.sv
`default_nettype none

module pns_ratio import pns_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             restart,
    input  wire logic [DIM_W-1:0] sw,
    input  wire logic [DIM_W-1:0] sh,
    input  wire logic [DIM_W-1:0] tw,
    input  wire logic [DIM_W-1:0] th,
    output ratio_t                status
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } rstate_t;

    rstate_t            state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [RATIO_W-1:0] xn_reg, xn_next, yn_reg, yn_next;
    logic [RATIO_W-1:0] xq_reg, xq_next, yq_reg, yq_next;
    logic [DIM_W-1:0]   xr_reg, xr_next, yr_reg, yr_next;
    logic [DIM_W:0]     xt, yt;
    logic               xge, yge;

    // shift-in long division, one bit per cycle for both axes
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        xn_next    = xn_reg;
        yn_next    = yn_reg;
        xq_next    = xq_reg;
        yq_next    = yq_reg;
        xr_next    = xr_reg;
        yr_next    = yr_reg;
        xt         = {xr_reg, xn_reg[RATIO_W-1]};
        yt         = {yr_reg, yn_reg[RATIO_W-1]};
        xge        = xt >= {1'b0, tw};
        yge        = yt >= {1'b0, th};
        case (state_reg)
            ST_LOAD:
            begin
                xn_next    = {sw, {FRAC_W{1'b0}}};
                yn_next    = {sh, {FRAC_W{1'b0}}};
                xq_next    = '0;
                yq_next    = '0;
                xr_next    = '0;
                yr_next    = '0;
                cnt_next   = 5'(RATIO_W - 1);
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                xr_next = xge ? DIM_W'(xt - {1'b0, tw}) : xt[DIM_W-1:0];
                yr_next = yge ? DIM_W'(yt - {1'b0, th}) : yt[DIM_W-1:0];
                xq_next = {xq_reg[RATIO_W-2:0], xge};
                yq_next = {yq_reg[RATIO_W-2:0], yge};
                xn_next = {xn_reg[RATIO_W-2:0], 1'b0};
                yn_next = {yn_reg[RATIO_W-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (restart)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        xn_reg  <= xn_next;
        yn_reg  <= yn_next;
        xq_reg  <= xq_next;
        yq_reg  <= yq_next;
        xr_reg  <= xr_next;
        yr_reg  <= yr_next;
    end

    assign status.busy    = (state_reg != ST_DONE);
    assign status.x_ratio = xq_reg + RATIO_W'(1);
    assign status.y_ratio = yq_reg + RATIO_W'(1);

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pns_pkg::*;

    localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             marg;
    } pixel_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [15:0]       cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              op = OP_LOAD;
    logic [ADDR_W-1:0] load_address = '0;
    logic [PIX_W-1:0]  load_pixel = '0;
    logic [7:0]        dest_x = '0;
    logic [7:0]        dest_y = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PIX_W-1:0]  pixel_out;
    logic              in_margin;

    // predictor state
    logic [PIX_W-1:0] image_mem [65536];
    bit               image_written [65536];
    int unsigned      src_w, src_h, tgt_w, tgt_h;
    bit               persp_on;
    logic [15:0]      bg_color;

    pixel_t      pixel_q [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    perspective_nearest_scaler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .load_address (load_address),
        .load_pixel   (load_pixel),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .in_margin    (in_margin)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    function automatic longint unsigned eff_dim(int unsigned v);
        if (v == 0)
            return 64'd1;
        if (v > 256)
            return 64'd256;
        return 64'(v);
    endfunction

    // nearest source index for a destination pixel, or margin / no beat
    function automatic void map_pixel(input logic [7:0] dx8, input logic [7:0] dy8,
                                      output bit has, output bit marg,
                                      output int unsigned idx);
        longint unsigned sw, sh, tw, th, dx, dy, yr, xr, sy, sx, c, row_dist, m, line;
        sw = eff_dim(src_w);
        sh = eff_dim(src_h);
        tw = eff_dim(tgt_w);
        th = eff_dim(tgt_h);
        dx = 64'(dx8);
        dy = 64'(dy8);
        has = 0;
        marg = 0;
        idx = 0;
        if (dx >= tw || dy >= th)
            return;
        has = 1;
        yr = ((sh << 16) / th) + 1;
        sy = (dy * yr) >> 16;
        if (sy >= sh)
            sy = sh - 1;
        if (persp_on)
        begin
            c = th / 2;
            row_dist = (dy < c) ? (c - dy) : (dy - c);
            m = (row_dist * tw) / (th * 3);
            if (dx < m || dx > tw - m)
            begin
                marg = 1;
                return;
            end
            line = (tw > 2 * m) ? (tw - 2 * m) : 1;
            sx = ((dx - m) * sw) / line;
        end
        else
        begin
            xr = ((sw << 16) / tw) + 1;
            sx = (dx * xr) >> 16;
        end
        if (sx >= sw)
            sx = sw - 1;
        idx = 32'((sy * sw + sx) % 65536);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // output checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_q.size() == 0)
                report("unexpected beat", 32'(pixel_out), 32'd0);
            else
            begin
                want = pixel_q.pop_front();
                if (pixel_out !== want.pix)
                    report("pixel_out", 32'(pixel_out), 32'(want.pix));
                if (in_margin !== want.marg)
                    report("in_margin", 32'(in_margin), 32'(want.marg));
            end
        end
    end

    // one input beat, model updated on acceptance
    task automatic send_beat(input logic o, input logic [15:0] addr, input logic [15:0] pix,
                             input logic [7:0] dx, input logic [7:0] dy);
        bit has, marg;
        int unsigned idx;
        pixel_t res;
        if ($urandom_range(99) < send_idle_pct)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        op = o;
        load_address = addr;
        load_pixel = pix;
        dest_x = dx;
        dest_y = dy;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (o == OP_LOAD)
        begin
            image_mem[addr] = pix;
            image_written[addr] = 1;
        end
        else
        begin
            map_pixel(dx, dy, has, marg, idx);
            if (has)
            begin
                res.marg = marg;
                res.pix = marg ? bg_color : image_mem[idx];
                pixel_q.push_back(res);
            end
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // sample, loading the chosen source pixel first if never written
    task automatic sample_pixel(input logic [7:0] dx, input logic [7:0] dy);
        bit has, marg;
        int unsigned idx;
        map_pixel(dx, dy, has, marg, idx);
        if (has && !marg && !image_written[idx])
            send_beat(OP_LOAD, idx[15:0], 16'($urandom), 8'($urandom), 8'($urandom));
        send_beat(OP_SAMPLE, 16'($urandom), 16'($urandom), dx, dy);
    endtask

    task automatic wait_idle();
        wait (pixel_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [15:0] val);
        wait_idle();
        cfg_index = idx;
        cfg_data = val;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  src_w = 32'(val[8:0]);
            REG_SOURCE_HEIGHT: src_h = 32'(val[8:0]);
            REG_TARGET_WIDTH:  tgt_w = 32'(val[8:0]);
            REG_TARGET_HEIGHT: tgt_h = 32'(val[8:0]);
            REG_PERSPECTIVE:   persp_on = val[0];
            REG_BACKGROUND:    bg_color = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                                input int unsigned tw, input int unsigned th, input bit p);
        write_reg(REG_SOURCE_WIDTH, 16'(sw));
        write_reg(REG_SOURCE_HEIGHT, 16'(sh));
        write_reg(REG_TARGET_WIDTH, 16'(tw));
        write_reg(REG_TARGET_HEIGHT, 16'(th));
        write_reg(REG_PERSPECTIVE, 16'(p));
    endtask

    // corners, ignored samples, clamped dimensions, margins
    task automatic test_directed();
        send_beat(OP_LOAD, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_beat(OP_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        sample_pixel(8'd0, 8'd0);
        sample_pixel(8'd159, 8'd159);
        sample_pixel(8'd160, 8'd0);
        sample_pixel(8'd0, 8'd160);
        sample_pixel(8'd255, 8'd255);
        set_geometry(0, 0, 256, 256, 1'b0);
        sample_pixel(8'd255, 8'd255);
        sample_pixel(8'd128, 8'd0);
        set_geometry(511, 300, 1, 1, 1'b0);
        sample_pixel(8'd0, 8'd0);
        sample_pixel(8'd1, 8'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_BACKGROUND, 16'h0000);
        set_geometry(256, 256, 256, 256, 1'b1);
        sample_pixel(8'd0, 8'd0);
        sample_pixel(8'd255, 8'd0);
        sample_pixel(8'd128, 8'd128);
        sample_pixel(8'd42, 8'd255);
        sample_pixel(8'd213, 8'd255);
        write_reg(REG_BACKGROUND, 16'hFFFF);
        sample_pixel(8'd0, 8'd255);
        set_geometry(1, 1, 3, 2, 1'b1);
        sample_pixel(8'd0, 8'd0);
        sample_pixel(8'd2, 8'd1);
    endtask

    // random geometry phases with mostly valid samples
    task automatic test_random(input int unsigned items, input int unsigned phases);
        int unsigned sel, per;
        int unsigned dims [4];
        per = items / phases;
        for (int p = 0; p < phases; p++)
        begin
            foreach (dims[i])
            begin
                sel = $urandom_range(9);
                if (sel == 0)
                    dims[i] = 256;
                else if (sel == 1)
                    dims[i] = $urandom_range(511);
                else
                    dims[i] = $urandom_range(1, 24);
            end
            set_geometry(dims[0], dims[1], dims[2], dims[3], 1'($urandom_range(1)));
            write_reg(REG_BACKGROUND, 16'($urandom));
            for (int n = 0; n < per; n++)
            begin
                sel = $urandom_range(99);
                if (n == per / 2 && p == 0)
                    wait (pixel_q.size() == 0);
                if (sel < 15)
                    send_beat(OP_LOAD, 16'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom));
                else if (sel < 25)
                    sample_pixel(8'($urandom), 8'($urandom));
                else
                    sample_pixel(8'($urandom_range(32'(eff_dim(tgt_w) - 1))),
                                 8'($urandom_range(32'(eff_dim(tgt_h) - 1))));
            end
        end
    endtask

    initial
    begin
        src_w = 160;
        src_h = 160;
        tgt_w = 160;
        tgt_h = 160;
        persp_on = 0;
        bg_color = 16'hFFFF;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 10;
        recv_stall_pct = 68;
        test_directed();
        test_random(400, 6);

        send_idle_pct = 68;
        recv_stall_pct = 10;
        test_random(400, 6);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(400, 6);

        wait_idle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> perspective_nearest_scaler.f
rtl/pns_pkg.sv
rtl/pns_ram.sv
rtl/pns_divpipe.sv
rtl/pns_ratio.sv
rtl/perspective_nearest_scaler.sv
verif/tb_top.sv
